>>> rtl/xzr_pkg.sv
// Shared types, fixed-point constants and the CORDIC arctangent steps for the XZ-plane rotator.
`default_nettype none

package xzr_pkg;

	// coordinate and angle formats
	localparam int COORD_WIDTH = 32;
	localparam int ANGLE_WIDTH = 16;
	localparam int GUARD       = 8;
	// headroom for negation and CORDIC growth (about 2.33x the input magnitude)
	localparam int WORK_WIDTH  = COORD_WIDTH + GUARD + 3;
	// residual angle in Q3.29
	localparam int ANG_WIDTH   = 32;
	localparam int ANG_FRAC    = 29;

	localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MAX = 16'sd25736;
	localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MIN = -16'sd25736;

	localparam logic signed [ANG_WIDTH-1:0] ANG_HALF_PI     = 32'sd843314856;
	localparam logic signed [ANG_WIDTH-1:0] ANG_NEG_HALF_PI = -32'sd843314856;
	localparam logic signed [ANG_WIDTH-1:0] ANG_PI          = 32'sd1686629713;

	// 1/K of the CORDIC gain, Q0.30
	localparam int GAIN_WIDTH = 30;
	localparam logic [GAIN_WIDTH-1:0] INV_GAIN = 30'd652032874;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_in;
		logic signed [COORD_WIDTH-1:0] y_in;
		logic signed [COORD_WIDTH-1:0] z_in;
		logic signed [ANGLE_WIDTH-1:0] angle_in;
	} vec_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_out;
		logic signed [COORD_WIDTH-1:0] y_out;
		logic signed [COORD_WIDTH-1:0] z_out;
		logic                          saturated;
	} vec_out_t;

	// payload carried down the rotation pipeline
	typedef struct packed {
		logic signed [WORK_WIDTH-1:0]  x;
		logic signed [WORK_WIDTH-1:0]  z;
		logic signed [ANG_WIDTH-1:0]   ang;
		logic signed [COORD_WIDTH-1:0] y;
	} cordic_t;

	// atan(2^-i) in Q3.29; past step 9 the cubic term rounds away
	function automatic logic signed [ANG_WIDTH-1:0] atan_step(input int unsigned idx);
		case (idx)
			0:       atan_step = 32'sd421657428;
			1:       atan_step = 32'sd248918915;
			2:       atan_step = 32'sd131521918;
			3:       atan_step = 32'sd66762579;
			4:       atan_step = 32'sd33510843;
			5:       atan_step = 32'sd16771758;
			6:       atan_step = 32'sd8387925;
			7:       atan_step = 32'sd4194219;
			8:       atan_step = 32'sd2097141;
			9:       atan_step = 32'sd1048575;
			default: atan_step = ANG_WIDTH'(1) << (ANG_FRAC - idx);
		endcase
	endfunction

endpackage

`default_nettype wire

>>> rtl/xz_plane_vector_rotation.sv
// The path from the accepting edge to the edge that takes the result holds one pre-rotation
//   stage, one register per CORDIC micro-rotation and three gain/round stages; done is high
//   in the cycle before that edge.
// Throughput: one vector per cycle; busy stays low, every stage advances each cycle.
// The receiver cannot stall: each result is on the ports for one cycle with done high.
// Reset clears every valid bit at once; data registers are not reset.
`default_nettype none

module xz_plane_vector_rotation
	import xzr_pkg::*;
#(
	parameter int unsigned CORDIC_STAGES = 16
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	output logic          busy,
	input  wire vec_in_t  vec,
	output logic          done,
	output vec_out_t      result
);

	localparam int unsigned LATENCY = CORDIC_STAGES + 4;

	logic signed [ANGLE_WIDTH-1:0] angle_cl;
	logic signed [ANG_WIDTH-1:0]   ang_raw;
	logic signed [ANG_WIDTH-1:0]   ang_cl;
	logic signed [WORK_WIDTH-1:0]  x_w;
	logic signed [WORK_WIDTH-1:0]  z_w;
	cordic_t                       pre;
	cordic_t                       pre_s1;
	logic                          pre_vld_s1;

	cordic_t                       chain [CORDIC_STAGES+1];
	logic [CORDIC_STAGES:0]        chain_vld;

	logic signed [COORD_WIDTH-1:0] x_fin;
	logic signed [COORD_WIDTH-1:0] z_fin;
	logic                          clip_x;
	logic                          clip_z;
	logic                          gvld_s1;
	logic                          gvld_s2;
	logic                          gvld_s3;
	logic signed [COORD_WIDTH-1:0] gy_s1;
	logic signed [COORD_WIDTH-1:0] gy_s2;
	logic signed [COORD_WIDTH-1:0] gy_s3;

	assign busy = 1'b0;

	// clamp the angle and fold it into -pi/2..pi/2 by negating the vector
	always_comb begin
		angle_cl = vec.angle_in;
		if (vec.angle_in > ANGLE_MAX) begin
			angle_cl = ANGLE_MAX;
		end else if (vec.angle_in < ANGLE_MIN) begin
			angle_cl = ANGLE_MIN;
		end
		ang_raw = {vec.angle_in, {(ANG_WIDTH-ANGLE_WIDTH){1'b0}}};
		ang_cl  = {angle_cl, {(ANG_WIDTH-ANGLE_WIDTH){1'b0}}};
		x_w     = WORK_WIDTH'(vec.x_in) <<< GUARD;
		z_w     = WORK_WIDTH'(vec.z_in) <<< GUARD;
		pre.y   = vec.y_in;
		if (ang_raw > ANG_HALF_PI) begin
			pre.ang = ang_cl - ANG_PI;
			pre.x   = -x_w;
			pre.z   = -z_w;
		end else if (ang_raw < ANG_NEG_HALF_PI) begin
			pre.ang = ang_cl + ANG_PI;
			pre.x   = -x_w;
			pre.z   = -z_w;
		end else begin
			pre.ang = ang_cl;
			pre.x   = x_w;
			pre.z   = z_w;
		end
	end

	// capture a transfer into the pre-rotation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_vld_s1 <= 1'b0;
		end else begin
			pre_vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		pre_s1 <= pre;
	end

	assign chain[0]     = pre_s1;
	assign chain_vld[0] = pre_vld_s1;

	// micro-rotation pipeline, one stage per iteration
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		xzr_cordic_stage #(
			.STAGE (i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.feed_vld (chain_vld[i]),
			.feed     (chain[i]),
			.rot_vld  (chain_vld[i+1]),
			.rot      (chain[i+1])
		);
	end

	// gain compensation for both rotated coordinates
	xzr_gain_sat u_gain_x (
		.clk   (clk),
		.raw   (chain[CORDIC_STAGES].x),
		.coord (x_fin),
		.clip  (clip_x)
	);

	xzr_gain_sat u_gain_z (
		.clk   (clk),
		.raw   (chain[CORDIC_STAGES].z),
		.coord (z_fin),
		.clip  (clip_z)
	);

	// carry valid alongside the gain stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gvld_s1 <= 1'b0;
			gvld_s2 <= 1'b0;
			gvld_s3 <= 1'b0;
		end else begin
			gvld_s1 <= chain_vld[CORDIC_STAGES];
			gvld_s2 <= gvld_s1;
			gvld_s3 <= gvld_s2;
		end
	end

	// hold y through the gain stages
	always_ff @(posedge clk) begin
		gy_s1 <= chain[CORDIC_STAGES].y;
		gy_s2 <= gy_s1;
		gy_s3 <= gy_s2;
	end

	// drive the result transfer
	assign done = gvld_s3;

	always_comb begin
		result.x_out     = x_fin;
		result.y_out     = gy_s3;
		result.z_out     = z_fin;
		result.saturated = clip_x || clip_z;
	end

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching input transfer");

	a_pre_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pre_vld_s1 |-> (pre_s1.ang <= ANG_HALF_PI) && (pre_s1.ang >= ANG_NEG_HALF_PI))
		else $error("folded angle outside -pi/2..pi/2");

	a_y_passes: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.y_out == $past(vec.y_in, LATENCY))
		else $error("y component changed on its way through");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |->
			(result.x_out == COORD_MAX) || (result.x_out == COORD_MIN) ||
			(result.z_out == COORD_MAX) || (result.z_out == COORD_MIN))
		else $error("saturation flag set with no coordinate at a limit");

endmodule

`default_nettype wire

>>> rtl/xzr_cordic_stage.sv
// One registered micro-rotation of the rotation-mode CORDIC pipeline.
`default_nettype none

module xzr_cordic_stage
	import xzr_pkg::*;
#(
	parameter int unsigned STAGE = 0
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           feed_vld,
	input  wire cordic_t  feed,
	output logic          rot_vld,
	output cordic_t       rot
);

	localparam logic signed [ANG_WIDTH-1:0] STEP = atan_step(STAGE);

	logic signed [WORK_WIDTH-1:0] dx;
	logic signed [WORK_WIDTH-1:0] dz;
	cordic_t                      nxt;
	logic                         rot_vld_s1;
	cordic_t                      rot_s1;

	assign dx = feed.z >>> STAGE;
	assign dz = feed.x >>> STAGE;

	// rotate toward zero residual angle
	always_comb begin
		nxt = feed;
		if (!feed.ang[ANG_WIDTH-1]) begin
			nxt.x   = feed.x - dx;
			nxt.z   = feed.z + dz;
			nxt.ang = feed.ang - STEP;
		end else begin
			nxt.x   = feed.x + dx;
			nxt.z   = feed.z - dz;
			nxt.ang = feed.ang + STEP;
		end
	end

	// advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_vld_s1 <= 1'b0;
		end else begin
			rot_vld_s1 <= feed_vld;
		end
	end

	// advance the payload
	always_ff @(posedge clk) begin
		rot_s1 <= nxt;
	end

	assign rot_vld = rot_vld_s1;
	assign rot     = rot_s1;

endmodule

`default_nettype wire

>>> rtl/xzr_gain_sat.sv
// Gain compensation, guard-bit rounding and saturation of one coordinate, three stages.
`default_nettype none

module xzr_gain_sat
	import xzr_pkg::*;
(
	input  wire                           clk,
	input  wire signed [WORK_WIDTH-1:0]   raw,
	output logic signed [COORD_WIDTH-1:0] coord,
	output logic                          clip
);

	// split the operand so each partial product stays near 21 x 30 bits
	localparam int LO_BITS = WORK_WIDTH / 2;
	localparam int HI_BITS = WORK_WIDTH - LO_BITS;
	localparam int PLO_W   = LO_BITS + GAIN_WIDTH;
	localparam int PHI_W   = HI_BITS + GAIN_WIDTH;
	localparam int SUM_W   = PHI_W + LO_BITS + 1;
	localparam int G_W     = SUM_W - GAIN_WIDTH;
	localparam int GX_W    = G_W + 1;
	localparam int R_W     = GX_W - GUARD;

	localparam logic signed [SUM_W-1:0] ROUND_G = SUM_W'(1) << (GAIN_WIDTH - 1);
	localparam logic signed [GX_W-1:0]  ROUND_R = GX_W'(1) << (GUARD - 1);

	logic signed [PHI_W-1:0]  hi_ext;
	logic signed [PHI_W-1:0]  gain_hi;
	logic [PLO_W-1:0]         lo_ext;
	logic [PLO_W-1:0]         gain_lo;
	logic signed [PHI_W-1:0]  prod_hi_s1;
	logic [PLO_W-1:0]         prod_lo_s1;
	logic signed [SUM_W-1:0]  sum;
	logic signed [G_W-1:0]    gain_s2;
	logic signed [GX_W-1:0]   rsum;
	logic signed [R_W-1:0]    rnd;
	logic [R_W-COORD_WIDTH:0] top_bits;
	logic                     ovf;
	logic signed [COORD_WIDTH-1:0] coord_s3;
	logic                     clip_s3;

	// the upper half carries the sign, the lower half is a plain magnitude
	assign hi_ext  = PHI_W'($signed(raw[WORK_WIDTH-1:LO_BITS]));
	assign gain_hi = PHI_W'(INV_GAIN);
	assign lo_ext  = PLO_W'(raw[LO_BITS-1:0]);
	assign gain_lo = PLO_W'(INV_GAIN);

	// stage 1: partial products
	always_ff @(posedge clk) begin
		prod_hi_s1 <= hi_ext * gain_hi;
		prod_lo_s1 <= lo_ext * gain_lo;
	end

	// stage 2: recombine and round half-up out of Q0.30
	assign sum = (SUM_W'(prod_hi_s1) <<< LO_BITS) + SUM_W'(prod_lo_s1) + ROUND_G;

	always_ff @(posedge clk) begin
		gain_s2 <= sum[SUM_W-1:GAIN_WIDTH];
	end

	// stage 3: drop guard bits half-up, then clip to the coordinate range
	assign rsum     = GX_W'(gain_s2) + ROUND_R;
	assign rnd      = rsum[GX_W-1:GUARD];
	assign top_bits = rnd[R_W-1:COORD_WIDTH-1];
	assign ovf      = !((&top_bits) || !(|top_bits));

	always_ff @(posedge clk) begin
		clip_s3 <= ovf;
		if (ovf) begin
			coord_s3 <= rnd[R_W-1] ? COORD_MIN : COORD_MAX;
		end else begin
			coord_s3 <= rnd[COORD_WIDTH-1:0];
		end
	end

	assign coord = coord_s3;
	assign clip  = clip_s3;

endmodule

`default_nettype wire
